FILE: sv/ftsc_pkg.sv
// Shared types, constants and helpers of the force/torque sensor conditioner.
package ftsc_pkg;

  localparam int unsigned SAMPLE_BITS = 32;
  localparam int unsigned NUM_FIELDS  = 6;
  localparam int unsigned LEN_W       = 5;
  localparam int unsigned CNT_W       = 10;
  localparam int unsigned SUM_W       = SAMPLE_BITS + LEN_W;
  localparam int unsigned DIV_W       = SAMPLE_BITS + CNT_W;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 32;

  localparam logic [CFG_IDX_W-1:0] REG_WIN_LEN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WARMUP  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CALIB   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_THRESH  = 2'd3;

  localparam logic [LEN_W-1:0]              WIN_LEN_RST = 5'd10;
  localparam logic [CNT_W-1:0]              WARMUP_RST  = 10'd100;
  localparam logic [CNT_W-1:0]              CALIB_RST   = 10'd500;
  localparam logic signed [SAMPLE_BITS-1:0] THRESH_RST  = 32'sd3277;

  typedef logic [NUM_FIELDS-1:0][SAMPLE_BITS-1:0] smp_vec_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] force_x;
    logic signed [SAMPLE_BITS-1:0] force_y;
    logic signed [SAMPLE_BITS-1:0] force_z;
    logic signed [SAMPLE_BITS-1:0] torque_x;
    logic signed [SAMPLE_BITS-1:0] torque_y;
    logic signed [SAMPLE_BITS-1:0] torque_z;
  } in_beat_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] filtered_force_x;
    logic signed [SAMPLE_BITS-1:0] filtered_force_y;
    logic signed [SAMPLE_BITS-1:0] filtered_force_z;
    logic signed [SAMPLE_BITS-1:0] filtered_torque_x;
    logic signed [SAMPLE_BITS-1:0] filtered_torque_y;
    logic signed [SAMPLE_BITS-1:0] filtered_torque_z;
    logic                          collision;
    logic                          impact;
  } out_beat_t;

  typedef enum logic [1:0] {
    KIND_CAL      = 2'd0,
    KIND_CAL_LAST = 2'd1,
    KIND_RUN      = 2'd2
  } job_kind_e;

  typedef struct packed {
    job_kind_e        kind;
    logic [LEN_W-1:0] len;
    logic [CNT_W-1:0] cnt;
  } job_ctl_t;

  function automatic smp_vec_t unpack_in(input in_beat_t b);
    smp_vec_t v;
    v[0] = b.force_x;
    v[1] = b.force_y;
    v[2] = b.force_z;
    v[3] = b.torque_x;
    v[4] = b.torque_y;
    v[5] = b.torque_z;
    return v;
  endfunction

  function automatic out_beat_t pack_out(input smp_vec_t f, input logic coll, input logic imp);
    out_beat_t o;
    o.filtered_force_x  = f[0];
    o.filtered_force_y  = f[1];
    o.filtered_force_z  = f[2];
    o.filtered_torque_x = f[3];
    o.filtered_torque_y = f[4];
    o.filtered_torque_z = f[5];
    o.collision         = coll;
    o.impact            = imp;
    return o;
  endfunction

  // Clamp a one-bit-wider difference to the sample range.
  function automatic logic [SAMPLE_BITS-1:0] sat_sample(input logic [SAMPLE_BITS:0] v);
    logic [SAMPLE_BITS-1:0] r;
    if (v[SAMPLE_BITS] != v[SAMPLE_BITS-1]) begin
      r = v[SAMPLE_BITS] ? {1'b1, {(SAMPLE_BITS-1){1'b0}}} : {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end else begin
      r = v[SAMPLE_BITS-1:0];
    end
    return r;
  endfunction

endpackage

FILE: sv/force_torque_sensor_conditioner_top.sv
// Six-axis force/torque conditioner: windowed means with offset calibration and contact flags.
// Input: one beat a cycle; a beat that closes a window past warmup stalls the input
// while the history is read and the job is pushed, longer while the job queue is full.
// Result: each window's means go through the 42-step divider lanes of the back end, and the last
// calibration window goes through them a second time for the offsets.
// Reset clears control, calibration sums, offsets and history valid bits; no clearing pass.
module force_torque_sensor_conditioner_top import ftsc_pkg::*; #(
  parameter int unsigned MAX_WINDOW = 16,
  parameter int unsigned CHANNELS   = 6
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_beat_t              in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_beat_t             out_data_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int unsigned CTL_W = $bits(job_ctl_t);
  localparam int unsigned JOB_W = CTL_W + CHANNELS * SUM_W;

  logic [LEN_W-1:0]              win_len_q;
  logic [CNT_W-1:0]              warmup_q;
  logic [CNT_W-1:0]              calib_q;
  logic signed [SAMPLE_BITS-1:0] thresh_q;

  logic                          fq_valid;
  logic                          fq_stall;
  job_ctl_t                      fq_ctl;
  logic [CHANNELS*SUM_W-1:0]     fq_sums;
  logic                          qb_valid;
  logic                          qb_stall;
  logic [JOB_W-1:0]              qb_data;
  job_ctl_t                      qb_ctl;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_len_q <= WIN_LEN_RST;
      warmup_q  <= WARMUP_RST;
      calib_q   <= CALIB_RST;
      thresh_q  <= THRESH_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_WIN_LEN: win_len_q <= cfg_wdata_i[LEN_W-1:0];
        REG_WARMUP:  warmup_q  <= cfg_wdata_i[CNT_W-1:0];
        REG_CALIB:   calib_q   <= cfg_wdata_i[CNT_W-1:0];
        REG_THRESH:  thresh_q  <= $signed(cfg_wdata_i[SAMPLE_BITS-1:0]);
      endcase
    end
  end

  ftsc_front #(
    .MAX_WINDOW (MAX_WINDOW),
    .CHANNELS   (CHANNELS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .win_len_i   (win_len_q),
    .warmup_i    (warmup_q),
    .calib_i     (calib_q),
    .job_valid_o (fq_valid),
    .job_stall_i (fq_stall),
    .job_ctl_o   (fq_ctl),
    .job_sums_o  (fq_sums)
  );

  ftsc_queue #(
    .WIDTH (JOB_W)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fq_valid),
    .push_stall_o (fq_stall),
    .push_data_i  ({fq_ctl, fq_sums}),
    .pop_valid_o  (qb_valid),
    .pop_stall_i  (qb_stall),
    .pop_data_o   (qb_data)
  );

  assign qb_ctl = job_ctl_t'(qb_data[JOB_W-1 -: CTL_W]);

  ftsc_back #(
    .CHANNELS (CHANNELS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (qb_valid),
    .job_stall_o (qb_stall),
    .job_ctl_i   (qb_ctl),
    .job_sums_i  (qb_data[CHANNELS*SUM_W-1:0]),
    .thresh_i    (thresh_q),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

FILE: sv/ftsc_div.sv
// Restoring divider lane, signed dividend over unsigned divisor: one bit a cycle on step_i.
module ftsc_div import ftsc_pkg::*; (
  input  logic                    clk_i,
  input  logic                    load_i,
  input  logic                    step_i,
  input  logic signed [DIV_W-1:0] dividend_i,
  input  logic [CNT_W-1:0]        divisor_i,
  output logic signed [DIV_W-1:0] quotient_o
);

  logic             neg_q;
  logic [DIV_W-1:0] quo_q;
  logic [CNT_W-1:0] rem_q;
  logic [CNT_W-1:0] dvs_q;
  logic [CNT_W:0]   rem_sh;
  logic [CNT_W:0]   rem_sub;
  logic             fit;

  assign rem_sh  = {rem_q, quo_q[DIV_W-1]};
  assign fit     = rem_sh >= {1'b0, dvs_q};
  assign rem_sub = rem_sh - {1'b0, dvs_q};

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      neg_q <= dividend_i[DIV_W-1];
      quo_q <= dividend_i[DIV_W-1] ? (~dividend_i + 1'b1) : dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (step_i) begin
      rem_q <= fit ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
      quo_q <= {quo_q[DIV_W-2:0], fit};
    end
  end

  // Truncate toward zero: divide magnitudes, then restore the sign.
  assign quotient_o = neg_q ? -$signed(quo_q) : $signed(quo_q);

endmodule

FILE: sv/ftsc_front.sv
// Front end: sample history memory, decimation, calibration phase tracking and window sums.
module ftsc_front import ftsc_pkg::*; #(
  parameter int unsigned MAX_WINDOW = 16,
  parameter int unsigned CHANNELS   = 6
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  in_beat_t                  in_data_i,
  input  logic [LEN_W-1:0]          win_len_i,
  input  logic [CNT_W-1:0]          warmup_i,
  input  logic [CNT_W-1:0]          calib_i,
  output logic                      job_valid_o,
  input  logic                      job_stall_i,
  output job_ctl_t                  job_ctl_o,
  output logic [CHANNELS*SUM_W-1:0] job_sums_o
);

  localparam int unsigned PTR_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int unsigned ROW_W = CHANNELS * SAMPLE_BITS;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(MAX_WINDOW - 1);

  typedef enum logic [2:0] {
    FS_IDLE = 3'b001,
    FS_SUM  = 3'b010,
    FS_PUSH = 3'b100
  } front_st_e;

  front_st_e st_q, st_d;

  logic [ROW_W-1:0]       mem [MAX_WINDOW];
  logic [MAX_WINDOW-1:0]  row_vld_q;
  logic [ROW_W-1:0]       row_in;
  logic [ROW_W-1:0]       rdata_q;
  logic                   rok_q;
  logic                   rvld_q;
  logic [PTR_W-1:0]       wptr_q;
  logic [PTR_W-1:0]       rptr_q;
  logic [LEN_W-1:0]       iss_q;
  logic [LEN_W-1:0]       tick_q;
  logic [LEN_W-1:0]       tick_nx;
  logic [LEN_W-1:0]       len_eff;
  logic [CNT_W-1:0]       warm_cnt_q;
  logic [CNT_W-1:0]       cal_cnt_q;
  logic [CNT_W-1:0]       cal_nx;
  logic [CNT_W-1:0]       need;
  logic                   calibrated_q;
  logic                   accept;
  logic                   evaluate;
  logic                   warm_skip;
  logic                   issue;
  logic                   sum_done;
  job_kind_e              kind;
  job_ctl_t               ctl_q;
  logic signed [SUM_W-1:0] acc_q [CHANNELS];
  smp_vec_t               smp;

  always_comb begin
    if (win_len_i == '0) begin
      len_eff = LEN_W'(1);
    end else if (32'(win_len_i) > MAX_WINDOW) begin
      len_eff = LEN_W'(MAX_WINDOW);
    end else begin
      len_eff = win_len_i;
    end
  end

  assign smp = unpack_in(in_data_i);

  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      row_in[c*SAMPLE_BITS +: SAMPLE_BITS] = smp[c];
    end
  end

  assign in_stall_o = (st_q != FS_IDLE);
  assign accept     = in_valid_i && (st_q == FS_IDLE);
  assign tick_nx    = tick_q + 1'b1;
  assign evaluate   = (tick_nx >= len_eff);
  assign warm_skip  = !calibrated_q && (warm_cnt_q < warmup_i);
  assign need       = (calib_i == '0) ? CNT_W'(1) : calib_i;
  assign cal_nx     = cal_cnt_q + 1'b1;

  always_comb begin
    if (calibrated_q) begin
      kind = KIND_RUN;
    end else if (cal_nx >= need) begin
      kind = KIND_CAL_LAST;
    end else begin
      kind = KIND_CAL;
    end
  end

  assign issue    = (st_q == FS_SUM) && (iss_q != ctl_q.len);
  assign sum_done = (st_q == FS_SUM) && (iss_q == ctl_q.len) && !rvld_q;

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      FS_IDLE: if (accept && evaluate && !warm_skip) st_d = FS_SUM;
      FS_SUM:  if (sum_done) st_d = FS_PUSH;
      FS_PUSH: if (!job_stall_i) st_d = FS_IDLE;
      default: st_d = FS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q         <= FS_IDLE;
      row_vld_q    <= '0;
      wptr_q       <= '0;
      tick_q       <= '0;
      warm_cnt_q   <= '0;
      cal_cnt_q    <= '0;
      calibrated_q <= 1'b0;
      rvld_q       <= 1'b0;
      iss_q        <= '0;
    end else begin
      st_q   <= st_d;
      rvld_q <= issue;
      if (accept) begin
        row_vld_q[wptr_q] <= 1'b1;
        wptr_q            <= (wptr_q == PTR_LAST) ? '0 : wptr_q + 1'b1;
        tick_q            <= evaluate ? '0 : tick_nx;
        iss_q             <= '0;
        if (evaluate) begin
          if (warm_skip) begin
            warm_cnt_q <= warm_cnt_q + 1'b1;
          end else if (!calibrated_q) begin
            cal_cnt_q <= cal_nx;
            if (kind == KIND_CAL_LAST) calibrated_q <= 1'b1;
          end
        end
      end else if (issue) begin
        iss_q <= iss_q + 1'b1;
      end
    end
  end

  // History rows: newest at wptr, read back newest first during the sum.
  always_ff @(posedge clk_i) begin
    if (accept) mem[wptr_q] <= row_in;
    rdata_q <= mem[rptr_q];
    rok_q   <= row_vld_q[rptr_q];
    if (accept) begin
      rptr_q <= wptr_q;
      ctl_q  <= '{kind: kind, len: len_eff, cnt: cal_nx};
    end else if (issue) begin
      rptr_q <= (rptr_q == '0) ? PTR_LAST : rptr_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < CHANNELS; c++) begin
      if (accept) begin
        acc_q[c] <= '0;
      end else if (rvld_q && rok_q) begin
        acc_q[c] <= acc_q[c] + SUM_W'($signed(rdata_q[c*SAMPLE_BITS +: SAMPLE_BITS]));
      end
    end
  end

  assign job_valid_o = (st_q == FS_PUSH);
  assign job_ctl_o   = ctl_q;

  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      job_sums_o[c*SUM_W +: SUM_W] = acc_q[c];
    end
  end

endmodule

FILE: sv/ftsc_queue.sv
// Two-entry queue of evaluation jobs between front and back ends.
module ftsc_queue #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_stall_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_stall_i,
  output logic [WIDTH-1:0] pop_data_o
);

  localparam int unsigned DEPTH = 2;
  localparam int unsigned PW    = $clog2(DEPTH);

  logic [WIDTH-1:0] ent_q [DEPTH];
  logic [PW-1:0]    wp_q;
  logic [PW-1:0]    rp_q;
  logic [PW:0]      cnt_q;
  logic             push;
  logic             pop;

  assign push_stall_o = (cnt_q == (PW+1)'(DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = ent_q[rp_q];
  assign push         = push_valid_i && !push_stall_o;
  assign pop          = pop_valid_o && !pop_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wp_q <= wp_q + 1'b1;
      if (pop)  rp_q <= rp_q + 1'b1;
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) ent_q[wp_q] <= push_data_i;
  end

endmodule

FILE: sv/ftsc_back.sv
// Back end: window means, calibration offsets, offset removal, contact flags, output register.
module ftsc_back import ftsc_pkg::*; #(
  parameter int unsigned CHANNELS = 6
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          job_valid_i,
  output logic                          job_stall_o,
  input  job_ctl_t                      job_ctl_i,
  input  logic [CHANNELS*SUM_W-1:0]     job_sums_i,
  input  logic signed [SAMPLE_BITS-1:0] thresh_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output out_beat_t                     out_data_o
);

  localparam int unsigned FZ_CH = (CHANNELS > 2) ? 2 : 0;
  localparam int unsigned STP_W = $clog2(DIV_W);
  localparam logic [STP_W-1:0] STP_LAST = STP_W'(DIV_W - 1);

  typedef enum logic [4:0] {
    BS_IDLE = 5'b00001,
    BS_MDIV = 5'b00010,
    BS_POST = 5'b00100,
    BS_ODIV = 5'b01000,
    BS_OFIN = 5'b10000
  } back_st_e;

  back_st_e st_q, st_d;

  job_ctl_t                      ctl_q;
  logic [STP_W-1:0]              stp_q;
  logic                          div_load;
  logic                          div_step;
  logic [CNT_W-1:0]              div_b;
  logic signed [DIV_W-1:0]       div_a     [CHANNELS];
  logic signed [DIV_W-1:0]       quo       [CHANNELS];
  logic signed [SAMPLE_BITS-1:0] mean      [CHANNELS];
  logic signed [DIV_W-1:0]       cal_sum_q [CHANNELS];
  logic signed [DIV_W-1:0]       cal_sum_d [CHANNELS];
  logic signed [SAMPLE_BITS-1:0] off_q     [CHANNELS];
  smp_vec_t                      filt;
  logic                          pop;
  logic                          out_free;
  logic                          out_wr;
  logic                          coll;
  logic                          imp;
  logic                          prev_coll_q;
  logic                          out_vld_q;
  out_beat_t                     out_q;

  assign job_stall_o = (st_q != BS_IDLE);
  assign pop         = job_valid_i && (st_q == BS_IDLE);
  assign out_free    = !out_vld_q || !out_stall_i;
  assign div_step    = (st_q == BS_MDIV) || (st_q == BS_ODIV);
  assign div_load    = pop || ((st_q == BS_POST) && (ctl_q.kind == KIND_CAL_LAST));
  assign div_b       = (st_q == BS_IDLE) ? CNT_W'(job_ctl_i.len) : ctl_q.cnt;

  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      mean[c]      = quo[c][SAMPLE_BITS-1:0];
      cal_sum_d[c] = cal_sum_q[c] + DIV_W'(mean[c]);
      div_a[c]     = (st_q == BS_IDLE) ? DIV_W'($signed(job_sums_i[c*SUM_W +: SUM_W]))
                                       : cal_sum_d[c];
    end
  end

  for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
    ftsc_div u_div (
      .clk_i      (clk_i),
      .load_i     (div_load),
      .step_i     (div_step),
      .dividend_i (div_a[g]),
      .divisor_i  (div_b),
      .quotient_o (quo[g])
    );
  end

  always_comb begin
    filt = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      filt[c] = sat_sample((SAMPLE_BITS+1)'(mean[c]) - (SAMPLE_BITS+1)'(off_q[c]));
    end
  end

  assign coll   = $signed(filt[FZ_CH]) > thresh_i;
  assign imp    = coll && !prev_coll_q;
  assign out_wr = (st_q == BS_POST) && (ctl_q.kind == KIND_RUN) && out_free;

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      BS_IDLE: if (pop) st_d = BS_MDIV;
      BS_MDIV: if (stp_q == STP_LAST) st_d = BS_POST;
      BS_POST: begin
        unique case (ctl_q.kind)
          KIND_RUN:      if (out_free) st_d = BS_IDLE;
          KIND_CAL_LAST: st_d = BS_ODIV;
          default:       st_d = BS_IDLE;
        endcase
      end
      BS_ODIV: if (stp_q == STP_LAST) st_d = BS_OFIN;
      BS_OFIN: st_d = BS_IDLE;
      default: st_d = BS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= BS_IDLE;
      stp_q       <= '0;
      out_vld_q   <= 1'b0;
      prev_coll_q <= 1'b0;
      for (int c = 0; c < CHANNELS; c++) begin
        cal_sum_q[c] <= '0;
        off_q[c]     <= '0;
      end
    end else begin
      st_q <= st_d;
      if (div_load) begin
        stp_q <= '0;
      end else if (div_step) begin
        stp_q <= stp_q + 1'b1;
      end
      if (out_wr) begin
        out_vld_q   <= 1'b1;
        prev_coll_q <= coll;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
      // Accumulate means while calibrating; offsets land after the second divide.
      if ((st_q == BS_POST) && (ctl_q.kind != KIND_RUN)) begin
        for (int c = 0; c < CHANNELS; c++) cal_sum_q[c] <= cal_sum_d[c];
      end
      if (st_q == BS_OFIN) begin
        for (int c = 0; c < CHANNELS; c++) off_q[c] <= quo[c][SAMPLE_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop)    ctl_q <= job_ctl_i;
    if (out_wr) out_q <= pack_out(filt, coll, imp);
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

FILE: sv/ftsc_checker.sv
// Port-level checks on the conditioner's result channel, bound to the top level.
module ftsc_checker import ftsc_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      out_valid_i,
  input logic      out_stall_i,
  input out_beat_t out_data_i
);

  logic prev_coll_q;

  // Track the collision flag of the last delivered beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_coll_q <= 1'b0;
    end else if (out_valid_i && !out_stall_i) begin
      prev_coll_q <= out_data_i.collision;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> out_valid_i && $stable(out_data_i))
    else $error("stalled result beat changed");

  a_impact_needs_coll: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !out_data_i.impact || out_data_i.collision)
    else $error("impact without collision");

  a_impact_edge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.impact |-> !prev_coll_q)
    else $error("impact while previous beat already collided");

  a_coll_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.collision && !out_data_i.impact |-> prev_coll_q)
    else $error("collision onset without impact");

endmodule

bind force_torque_sensor_conditioner_top ftsc_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_i  (out_data_o)
);

FILE: tb/testbench.sv
// Self-checking testbench for the force/torque sensor conditioner top level.
module testbench;
  import ftsc_pkg::*;

  localparam int     MAX_WIN        = 16;
  localparam int     FZ             = 2;
  localparam int     DRAIN_CYCLES   = 200;
  localparam int     END_LIMIT      = 20000;
  localparam int     TIMEOUT_CYCLES = 800000;
  localparam int     HOLD_CYCLES    = 600;
  localparam int     RAND_PHASES    = 9;
  localparam int     PHASE_ITEMS    = 58;
  localparam int     PRINT_CAP      = 40;
  localparam longint SAMPLE_MAX     = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
  localparam longint SAMPLE_MIN     = -SAMPLE_MAX - 1;
  localparam logic [SAMPLE_BITS-1:0] S_MAX = 32'h7fff_ffff;
  localparam logic [SAMPLE_BITS-1:0] S_MIN = 32'h8000_0000;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  in_beat_t              in_data_i   = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  out_beat_t             out_data_o;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;

  force_torque_sensor_conditioner_top u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #6 clk_i = ~clk_i;

  // Conditioner state as the predictor tracks it.
  logic [LEN_W-1:0]              cfg_len  = WIN_LEN_RST;
  logic [CNT_W-1:0]              cfg_warm = WARMUP_RST;
  logic [CNT_W-1:0]              cfg_cal  = CALIB_RST;
  logic signed [SAMPLE_BITS-1:0] cfg_thr  = THRESH_RST;
  logic signed [SAMPLE_BITS-1:0] history [NUM_FIELDS][MAX_WIN];
  longint                        cal_acc  [NUM_FIELDS];
  longint                        chan_ofs [NUM_FIELDS];
  int                            tick_cnt  = 0;
  int                            warm_cnt  = 0;
  int                            cal_cnt   = 0;
  bit                            cal_done  = 1'b0;
  bit                            last_coll = 1'b0;

  out_beat_t filtered_q [$];
  in_beat_t  sample_q [$];

  string chan_name [NUM_FIELDS] = '{"filtered_force_x", "filtered_force_y", "filtered_force_z",
                                    "filtered_torque_x", "filtered_torque_y", "filtered_torque_z"};

  int err_count       = 0;
  int samples_queued  = 0;
  int samples_taken   = 0;
  int results_checked = 0;
  int contact_count   = 0;
  int impact_count    = 0;
  int send_idle_pct   = 16;
  int recv_idle_pct   = 50;
  int hold_reqs       = 0;
  int hold_seen       = 0;
  int hold_left       = 0;
  bit in_beat_taken   = 1'b0;

  initial begin
    for (int c = 0; c < NUM_FIELDS; c++) begin
      cal_acc[c]  = 0;
      chan_ofs[c] = 0;
      for (int i = 0; i < MAX_WIN; i++) history[c][i] = '0;
    end
  end

  task automatic report_mismatch(input string msg);
    if (err_count < PRINT_CAP) $display("ERROR @%0t: %s", $time, msg);
    err_count++;
  endtask

  // Shift one sample into the window history and, on a window boundary, form the
  // means; during calibration accumulate them, afterwards queue the filtered beat.
  task automatic condition_sample(input in_beat_t s);
    int                     len;
    longint                 acc;
    longint                 diff;
    longint                 mean [NUM_FIELDS];
    logic [SAMPLE_BITS-1:0] fv [NUM_FIELDS];
    bit                     coll;
    out_beat_t              r;
    len = (cfg_len == 0) ? 1 : ((cfg_len > MAX_WIN) ? MAX_WIN : int'(cfg_len));
    for (int c = 0; c < NUM_FIELDS; c++) begin
      for (int i = MAX_WIN - 1; i > 0; i--) history[c][i] = history[c][i-1];
      history[c][0] = s[(NUM_FIELDS-1-c)*SAMPLE_BITS +: SAMPLE_BITS];
    end
    tick_cnt++;
    if (tick_cnt < len) return;
    tick_cnt = 0;
    for (int c = 0; c < NUM_FIELDS; c++) begin
      acc = 0;
      for (int i = 0; i < len; i++) acc += history[c][i];
      mean[c] = acc / len;
    end
    if (!cal_done) begin
      if (warm_cnt < cfg_warm) begin
        warm_cnt++;
        return;
      end
      for (int c = 0; c < NUM_FIELDS; c++) cal_acc[c] += mean[c];
      cal_cnt++;
      if (cal_cnt >= ((cfg_cal == 0) ? 1 : int'(cfg_cal))) begin
        for (int c = 0; c < NUM_FIELDS; c++) chan_ofs[c] = cal_acc[c] / cal_cnt;
        cal_done = 1'b1;
      end
      return;
    end
    for (int c = 0; c < NUM_FIELDS; c++) begin
      diff = mean[c] - chan_ofs[c];
      if (diff > SAMPLE_MAX) diff = SAMPLE_MAX;
      else if (diff < SAMPLE_MIN) diff = SAMPLE_MIN;
      fv[c] = diff[SAMPLE_BITS-1:0];
    end
    coll = $signed(fv[FZ]) > cfg_thr;
    r.filtered_force_x  = fv[0];
    r.filtered_force_y  = fv[1];
    r.filtered_force_z  = fv[2];
    r.filtered_torque_x = fv[3];
    r.filtered_torque_y = fv[4];
    r.filtered_torque_z = fv[5];
    r.collision         = coll;
    r.impact            = coll && !last_coll;
    last_coll           = coll;
    contact_count += coll;
    impact_count  += r.impact;
    filtered_q.push_back(r);
  endtask

  // Input side: take beats at the rising edge and predict their results.
  always @(posedge clk_i) begin
    in_beat_taken <= rst_ni && in_valid_i && !in_stall_o;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      condition_sample(in_data_i);
      samples_taken++;
    end
  end

  always @(negedge clk_i) begin
    if (in_valid_i && !in_beat_taken) begin
      // hold the stalled beat
    end else if (rst_ni && sample_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
      in_valid_i <= 1'b1;
      in_data_i  <= sample_q.pop_front();
    end else begin
      in_valid_i <= 1'b0;
    end
  end

  // Output stall: random, or a long hold-off when one is requested.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (hold_seen != hold_reqs) begin
      hold_seen   <= hold_reqs;
      hold_left   <= HOLD_CYCLES;
      out_stall_i <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    out_beat_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (filtered_q.size() == 0) begin
        report_mismatch("result beat with no expectation pending");
      end else begin
        want = filtered_q.pop_front();
        results_checked++;
        for (int c = 0; c < NUM_FIELDS; c++) begin
          if (out_data_o[2+(NUM_FIELDS-1-c)*SAMPLE_BITS +: SAMPLE_BITS] !==
              want[2+(NUM_FIELDS-1-c)*SAMPLE_BITS +: SAMPLE_BITS])
            report_mismatch($sformatf("result %0d %s: got %0d, expected %0d",
              results_checked, chan_name[c],
              $signed(out_data_o[2+(NUM_FIELDS-1-c)*SAMPLE_BITS +: SAMPLE_BITS]),
              $signed(want[2+(NUM_FIELDS-1-c)*SAMPLE_BITS +: SAMPLE_BITS])));
        end
        if (out_data_o.collision !== want.collision)
          report_mismatch($sformatf("result %0d collision: got %b, expected %b",
            results_checked, out_data_o.collision, want.collision));
        if (out_data_o.impact !== want.impact)
          report_mismatch($sformatf("result %0d impact: got %b, expected %b",
            results_checked, out_data_o.impact, want.impact));
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    case (idx)
      REG_WIN_LEN: cfg_len  = value[LEN_W-1:0];
      REG_WARMUP:  cfg_warm = value[CNT_W-1:0];
      REG_CALIB:   cfg_cal  = value[CNT_W-1:0];
      REG_THRESH:  cfg_thr  = value;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic queue_sample(input in_beat_t b);
    sample_q.push_back(b);
    samples_queued++;
  endtask

  // Wait until every queued sample is in and every expected beat is out, then let
  // the back end settle on windows that produce nothing.
  task automatic wait_idle();
    while (samples_taken != samples_queued || filtered_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  initial begin
    #(TIMEOUT_CYCLES * 12);
    $display("DONE: errors detected");
    $finish;
  end

  initial begin : stimulus
    in_beat_t               b;
    logic [SAMPLE_BITS-1:0] v;
    logic [CFG_DATA_W-1:0]  len;
    logic [CFG_DATA_W-1:0]  thr;
    int                     pick;
    int                     waited;

    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Short warmup and calibration so results start early.
    write_reg(REG_WIN_LEN, 2);
    write_reg(REG_WARMUP, 2);
    write_reg(REG_CALIB, 6);
    write_reg(REG_THRESH, 32'h0001_0000);
    queue_sample(in_beat_t'({NUM_FIELDS{S_MAX}}));
    queue_sample(in_beat_t'({NUM_FIELDS{S_MIN}}));
    queue_sample('0);
    queue_sample(in_beat_t'({3{32'haaaa_aaaa, 32'h5555_5555}}));
    // Calibration windows: extreme offsets on force x/y, small one on force z.
    for (int n = 0; n < 6; n++)
      queue_sample('{force_x: S_MAX, force_y: S_MIN, force_z: 32'h0000_8000,
                     torque_x: $urandom, torque_y: 32'hffff_ffff, torque_z: 32'h1});
    wait_idle();
    // Lower the calibration count below what is reached: the next window ends it.
    write_reg(REG_CALIB, 0);
    write_reg(REG_WIN_LEN, 1);
    queue_sample('{force_x: S_MAX, force_y: S_MIN, force_z: 32'h0000_8000,
                   torque_x: $urandom, torque_y: 32'hffff_ffff, torque_z: 32'h1});
    queue_sample(in_beat_t'({NUM_FIELDS{S_MIN}}));
    queue_sample(in_beat_t'({NUM_FIELDS{S_MAX}}));
    queue_sample('{force_z: 32'h0002_8000, default: '0});
    queue_sample('{force_z: 32'h0002_8000, default: '0});
    queue_sample('0);
    wait_idle();
    // Warmup and calibration counts no longer matter once offsets are set.
    write_reg(REG_WARMUP, 1023);
    write_reg(REG_CALIB, 1023);
    write_reg(REG_THRESH, S_MIN);
    queue_sample('0);
    wait_idle();
    write_reg(REG_WIN_LEN, 31);
    for (int n = 0; n < 5; n++) queue_sample(in_beat_t'({$urandom, $urandom, $urandom,
                                                         $urandom, $urandom, $urandom}));
    wait_idle();
    // Shorter period than the count already reached: the next sample closes the window.
    write_reg(REG_WIN_LEN, 3);
    queue_sample(in_beat_t'({NUM_FIELDS{32'h0001_0000}}));
    wait_idle();
    write_reg(REG_WIN_LEN, 0);
    write_reg(REG_THRESH, S_MAX);
    queue_sample(in_beat_t'({NUM_FIELDS{S_MAX}}));
    queue_sample(in_beat_t'({NUM_FIELDS{32'h7fff_0000}}));

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      wait_idle();
      send_idle_pct = (ph < 3) ? 16 : ((ph < 6) ? 50 : 0);
      recv_idle_pct = (ph < 3) ? 50 : ((ph < 6) ? 16 : 0);
      pick = $urandom_range(9);
      if (pick < 5)      len = $urandom_range(4, 1);
      else if (pick < 8) len = $urandom_range(16, 5);
      else if (pick < 9) len = $urandom_range(31, 17);
      else               len = 0;
      if (ph == 4) len = 1;
      if (ph == RAND_PHASES - 1) len = 16;
      write_reg(REG_WIN_LEN, len);
      pick = $urandom_range(9);
      if (pick < 7)      thr = $urandom_range(131071) - 65536;
      else if (pick < 8) thr = S_MIN;
      else if (pick < 9) thr = S_MAX;
      else               thr = $urandom;
      write_reg(REG_THRESH, thr);
      if (ph % 3 == 1) begin
        write_reg(REG_WARMUP, $urandom_range(1023));
        write_reg(REG_CALIB, $urandom_range(1023));
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        for (int c = 0; c < NUM_FIELDS; c++) begin
          pick = $urandom_range(99);
          if (c == FZ && pick < 60)
            v = chan_ofs[FZ][SAMPLE_BITS-1:0] + cfg_thr + ($urandom_range(65535) - 32768);
          else if (pick < 50) v = $urandom_range(262143) - 131072;
          else if (pick < 85) v = $urandom;
          else begin
            case ($urandom_range(3))
              0:       v = S_MAX;
              1:       v = S_MIN;
              2:       v = '0;
              default: v = '1;
            endcase
          end
          b[(NUM_FIELDS-1-c)*SAMPLE_BITS +: SAMPLE_BITS] = v;
        end
        queue_sample(b);
      end
      if (ph == 4) begin
        // Stop the output for a long stretch while samples keep coming.
        @(posedge clk_i);
        hold_reqs++;
      end
    end

    while (samples_taken != samples_queued) @(negedge clk_i);
    waited = 0;
    while (filtered_q.size() != 0 && waited < END_LIMIT) begin
      @(negedge clk_i);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (filtered_q.size() != 0)
      report_mismatch($sformatf("%0d expected results never came out", filtered_q.size()));

    $display("Run covered %0d samples and %0d filtered results (%0d in contact, %0d impacts),",
             samples_taken, results_checked, contact_count, impact_count);
    $display("across window lengths 1 to 16, threshold extremes and a long output hold-off.");
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
